// File: hdl/rrs_pkg.sv
package rrs_pkg;

  // Default size of the process table.
  localparam int MAX_PROCS_DEF = 16;
  // At most this many result beats leave one run.
  localparam int RESULT_CAP = 16;

  typedef struct packed {
    logic [15:0] proc_tag;
    logic [15:0] arrival;
    logic [15:0] burst;
    logic        last_proc;
  } in_t;

  typedef struct packed {
    logic [15:0] out_tag;
    logic [15:0] out_arrival;
    logic [15:0] out_burst;
    logic [22:0] completion;
    logic [22:0] turnaround;
    logic [22:0] waiting;
    logic [22:0] response;
    logic [28:0] sum_waiting;
    logic [28:0] sum_turnaround;
    logic [28:0] sum_response;
    logic        run_end;
  } out_t;

  // One word of the process record memory.
  typedef struct packed {
    logic [15:0] tag;
    logic [15:0] arr;
    logic [15:0] burst;
    logic [15:0] rem;
    logic [22:0] first;
  } rec_t;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic load;
    logic rd_pop;
    logic adm_chk;
    logic min_init;
    logic min_chk;
    logic time_jump;
    logic pop;
    logic slice;
    logic push_cur;
    logic result;
    logic clear_run;
  } cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic fifo_empty;
    logic done_all;
    logic best_none;
    logic rem_zero;
    logic out_busy;
  } sts_t;

endpackage

// File: hdl/rrs_ram.sv
module rrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/rrs_ctrl.sv
module rrs_ctrl import rrs_pkg::*; #(
  parameter int MAX_PROCS = MAX_PROCS_DEF,
  localparam int CW = $clog2(MAX_PROCS + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_last,
  output logic          in_stall,
  input  logic [CW-1:0] n_loaded,
  input  sts_t          sts,
  output cmd_t          cmd,
  output logic [CW-1:0] scan_idx
);

  localparam logic [3:0] S_LOAD    = 4'd0;
  localparam logic [3:0] S_ADM_RD  = 4'd1;
  localparam logic [3:0] S_ADM_CHK = 4'd2;
  localparam logic [3:0] S_TOP     = 4'd3;
  localparam logic [3:0] S_MIN_RD  = 4'd4;
  localparam logic [3:0] S_MIN_CHK = 4'd5;
  localparam logic [3:0] S_MIN_END = 4'd6;
  localparam logic [3:0] S_POP     = 4'd7;
  localparam logic [3:0] S_SLICE   = 4'd8;
  localparam logic [3:0] S_POST    = 4'd9;
  localparam logic [3:0] S_RES     = 4'd10;

  logic [3:0]    state, state_next;
  logic [CW-1:0] idx, idx_next;
  logic          post, post_next;

  assign in_stall = (state != S_LOAD);
  assign scan_idx = idx;

  // Next state and command decode.
  always_comb begin
    state_next = state;
    idx_next   = idx;
    post_next  = post;
    cmd        = '0;
    case (state)
      S_LOAD: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last) begin
            idx_next   = '0;
            post_next  = 1'b0;
            state_next = S_ADM_RD;
          end
        end
      end
      S_ADM_RD: begin
        if (idx == n_loaded) begin
          state_next = post ? S_POST : S_TOP;
        end else begin
          state_next = S_ADM_CHK;
        end
      end
      S_ADM_CHK: begin
        cmd.adm_chk = 1'b1;
        idx_next    = idx + 1'b1;
        state_next  = S_ADM_RD;
      end
      S_TOP: begin
        if (sts.done_all) begin
          cmd.clear_run = 1'b1;
          state_next    = S_LOAD;
        end else if (sts.fifo_empty) begin
          cmd.min_init = 1'b1;
          idx_next     = '0;
          state_next   = S_MIN_RD;
        end else begin
          state_next = S_POP;
        end
      end
      S_MIN_RD: begin
        if (idx == n_loaded) begin
          state_next = S_MIN_END;
        end else begin
          state_next = S_MIN_CHK;
        end
      end
      S_MIN_CHK: begin
        cmd.min_chk = 1'b1;
        idx_next    = idx + 1'b1;
        state_next  = S_MIN_RD;
      end
      S_MIN_END: begin
        if (sts.best_none) begin
          cmd.clear_run = 1'b1;
          state_next    = S_LOAD;
        end else begin
          cmd.time_jump = 1'b1;
          idx_next      = '0;
          post_next     = 1'b0;
          state_next    = S_ADM_RD;
        end
      end
      S_POP: begin
        cmd.pop    = 1'b1;
        cmd.rd_pop = 1'b1;
        state_next = S_SLICE;
      end
      S_SLICE: begin
        cmd.slice  = 1'b1;
        idx_next   = '0;
        post_next  = 1'b1;
        state_next = S_ADM_RD;
      end
      S_POST: begin
        if (sts.rem_zero) begin
          state_next = S_RES;
        end else begin
          cmd.push_cur = 1'b1;
          state_next   = S_TOP;
        end
      end
      S_RES: begin
        if (!sts.out_busy) begin
          cmd.result = 1'b1;
          state_next = S_TOP;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      idx   <= '0;
      post  <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      post  <= post_next;
    end
  end

endmodule

// File: hdl/rrs_dp.sv
module rrs_dp import rrs_pkg::*; #(
  parameter int MAX_PROCS = MAX_PROCS_DEF,
  localparam int CW = $clog2(MAX_PROCS + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  cmd_t          cmd,
  input  logic [CW-1:0] scan_idx,
  input  in_t           in_data,
  input  logic          cfg_we,
  input  logic [15:0]   cfg_data,
  output sts_t          sts,
  output logic [CW-1:0] n_loaded,
  output logic          out_valid,
  input  logic          out_stall,
  output out_t          out_data
);

  localparam int IW  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int OCW = $clog2(RESULT_CAP + 1);

  logic [15:0]          quantum;
  logic [MAX_PROCS-1:0] seen;
  logic [CW-1:0]        loaded, done, qcnt;
  logic [IW-1:0]        head, tail, cur;
  logic [22:0]          sim_time;
  logic [15:0]          best;
  logic                 found;
  logic [OCW-1:0]       out_cnt;
  logic [28:0]          sum_w, sum_t, sum_r;
  rec_t                 crec;

  logic          rec_we;
  logic [IW-1:0] rec_waddr, rec_raddr, scan_slot;
  rec_t          rec_wdata, rd;
  logic          fifo_we;
  logic [IW-1:0] fifo_wdata, fifo_rdata;

  logic [15:0] q_eff, slice_len, rem_new;
  logic [22:0] first_new, tat, wt;
  logic        adm_hit, full, push, emit;
  logic [CW-1:0] done_inc;

  assign scan_slot = scan_idx[IW-1:0];
  assign full      = (loaded == CW'(MAX_PROCS));
  assign n_loaded  = loaded;

  // Slice arithmetic on the record just read.
  assign q_eff     = (quantum == 16'd0) ? 16'd1 : quantum;
  assign slice_len = (rd.rem <= q_eff) ? rd.rem : q_eff;
  assign rem_new   = rd.rem - slice_len;
  assign first_new = (rd.rem == rd.burst) ? (sim_time - {7'b0, rd.arr}) : rd.first;

  // Admission test of the scanned slot.
  assign adm_hit = !seen[scan_slot] && ({7'b0, rd.arr} <= sim_time);
  assign push    = (cmd.adm_chk && adm_hit) || cmd.push_cur;

  // Completion figures of the current process.
  assign tat      = sim_time - {7'b0, crec.arr};
  assign wt       = tat - {7'b0, crec.burst};
  assign done_inc = done + 1'b1;
  assign emit     = cmd.result && (out_cnt < OCW'(RESULT_CAP));

  // Record memory ports.
  always_comb begin
    rec_we    = (cmd.load && !full) || cmd.slice;
    rec_waddr = cmd.load ? loaded[IW-1:0] : cur;
    if (cmd.load) begin
      rec_wdata = '{tag: in_data.proc_tag, arr: in_data.arrival, burst: in_data.burst,
                    rem: in_data.burst, first: 23'd0};
    end else begin
      rec_wdata = '{tag: rd.tag, arr: rd.arr, burst: rd.burst, rem: rem_new,
                    first: first_new};
    end
    rec_raddr = cmd.rd_pop ? fifo_rdata : scan_slot;
  end

  rrs_ram #(.WIDTH($bits(rec_t)), .DEPTH(MAX_PROCS)) u_rec (
    .clk   (clk),
    .we    (rec_we),
    .waddr (rec_waddr),
    .wdata (rec_wdata),
    .raddr (rec_raddr),
    .rdata (rd)
  );

  // Ready queue memory.
  assign fifo_we    = push && (qcnt < CW'(MAX_PROCS));
  assign fifo_wdata = cmd.push_cur ? cur : scan_slot;

  rrs_ram #(.WIDTH(IW), .DEPTH(MAX_PROCS)) u_fifo (
    .clk   (clk),
    .we    (fifo_we),
    .waddr (tail),
    .wdata (fifo_wdata),
    .raddr (head),
    .rdata (fifo_rdata)
  );

  assign sts.fifo_empty = (qcnt == '0);
  assign sts.done_all   = (done == loaded);
  assign sts.best_none  = !found;
  assign sts.rem_zero   = (crec.rem == 16'd0);
  assign sts.out_busy   = out_valid && out_stall;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      quantum <= 16'd1;
    end else if (cfg_we) begin
      quantum <= cfg_data;
    end
  end

  // Run control state: counts, queue pointers, time and flags.
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_run) begin
      seen     <= '0;
      loaded   <= '0;
      done     <= '0;
      qcnt     <= '0;
      head     <= '0;
      tail     <= '0;
      sim_time <= '0;
      found    <= 1'b0;
      out_cnt  <= '0;
      sum_w    <= '0;
      sum_t    <= '0;
      sum_r    <= '0;
    end else begin
      if (cmd.load && !full) begin
        loaded <= loaded + 1'b1;
      end
      if (cmd.adm_chk && adm_hit) begin
        seen[scan_slot] <= 1'b1;
      end
      if (fifo_we) begin
        tail <= (tail == IW'(MAX_PROCS - 1)) ? '0 : tail + 1'b1;
      end
      if (cmd.pop) begin
        head <= (head == IW'(MAX_PROCS - 1)) ? '0 : head + 1'b1;
      end
      if (fifo_we && !cmd.pop) begin
        qcnt <= qcnt + 1'b1;
      end else if (cmd.pop && !fifo_we) begin
        qcnt <= qcnt - 1'b1;
      end
      if (cmd.min_init) begin
        found <= 1'b0;
      end else if (cmd.min_chk && !seen[scan_slot] && (!found || rd.arr < best)) begin
        found <= 1'b1;
      end
      if (cmd.time_jump) begin
        sim_time <= {7'b0, best};
      end else if (cmd.slice) begin
        sim_time <= sim_time + {7'b0, slice_len};
      end
      if (cmd.result) begin
        done  <= done_inc;
        sum_w <= sum_w + {6'b0, wt};
        sum_t <= sum_t + {6'b0, tat};
        sum_r <= sum_r + {6'b0, crec.first};
        if (out_cnt < OCW'(RESULT_CAP)) begin
          out_cnt <= out_cnt + 1'b1;
        end
      end
    end
  end

  // Payload registers of the current process and the minimum search.
  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      cur <= fifo_rdata;
    end
    if (cmd.slice) begin
      crec <= '{tag: rd.tag, arr: rd.arr, burst: rd.burst, rem: rem_new, first: first_new};
    end
    if (cmd.min_chk && !seen[scan_slot] && (!found || rd.arr < best)) begin
      best <= rd.arr;
    end
  end

  // Output register: holds a beat until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data.out_tag        <= crec.tag;
      out_data.out_arrival    <= crec.arr;
      out_data.out_burst      <= crec.burst;
      out_data.completion     <= sim_time;
      out_data.turnaround     <= tat;
      out_data.waiting        <= wt;
      out_data.response       <= crec.first;
      out_data.sum_waiting    <= sum_w + {6'b0, wt};
      out_data.sum_turnaround <= sum_t + {6'b0, tat};
      out_data.sum_response   <= sum_r + {6'b0, crec.first};
      out_data.run_end        <= (done_inc == loaded);
    end
  end

endmodule

// File: hdl/round_robin_schedule_sim.sv
// Round-robin scheduling engine.
// Input channel (in_valid, in_stall, in_data): each beat loads one process
// record into the next free table slot; records past the table size are
// dropped. A beat with last_proc set starts the run over all loaded records.
// While loading, one record is taken per cycle. During a run in_stall is high.
// The run opens with an arrival scan over all loaded records. Each slice
// then pops the ready queue, runs the slice, scans the record memory for
// new arrivals and requeues the process or, when it completes, emits its
// result; an empty queue starts a next-arrival search over the records,
// followed by another arrival scan; these memory scans set the run length.
// Output channel (out_valid, out_stall, out_data): one beat per completed
// process, in completion order, with running totals; run_end marks the last.
// When the receiver stalls, the held beat waits in the output register and
// the run pauses only at its next completion. Loading of the next batch may
// begin while the final beat of a run still waits.
// cfg_we and cfg_data write the time slice length; write it only while idle.
// Reset is synchronous: it empties the table and queue and sets the slice to 1.
module round_robin_schedule_sim import rrs_pkg::*; #(
  parameter int MAX_PROCS = MAX_PROCS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data
);

  localparam int CW = $clog2(MAX_PROCS + 1);

  cmd_t          cmd;
  sts_t          sts;
  logic [CW-1:0] scan_idx;
  logic [CW-1:0] n_loaded;

  rrs_ctrl #(.MAX_PROCS(MAX_PROCS)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_last  (in_data.last_proc),
    .in_stall (in_stall),
    .n_loaded (n_loaded),
    .sts      (sts),
    .cmd      (cmd),
    .scan_idx (scan_idx)
  );

  rrs_dp #(.MAX_PROCS(MAX_PROCS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .scan_idx  (scan_idx),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .sts       (sts),
    .n_loaded  (n_loaded),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // The final load beat always starts a run.
  a_last_starts_run: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_data.last_proc |=> in_stall)
    else $error("last record did not start a run");

  // The queue is empty whenever records are being loaded.
  a_idle_queue_empty: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> sts.fifo_empty)
    else $error("ready queue not empty while loading");

  // A dispatch never pops an empty queue.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> !sts.fifo_empty)
    else $error("pop from empty ready queue");

endmodule
